@@ rtl/core/xtea_pkg.sv @@
`default_nettype none

package xtea_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned KEY_WORDS  = 4;

   // Round constant and the shift that picks the key word for the half-round that updates z.
   localparam logic [WORD_WIDTH-1:0] XT_DELTA     = 32'h9E37_79B9;
   localparam int unsigned           XT_SEL_SHIFT = 11;

   typedef enum logic [1:0] {
      CSR_KEY_WORD0 = 2'd0,
      CSR_KEY_WORD1 = 2'd1,
      CSR_KEY_WORD2 = 2'd2,
      CSR_KEY_WORD3 = 2'd3
   } csr_index_type;

   typedef logic [KEY_WORDS-1:0][WORD_WIDTH-1:0] key_type;

   typedef struct packed {
      logic                  decrypt;
      logic [WORD_WIDTH-1:0] block_high;
      logic [WORD_WIDTH-1:0] block_low;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] result_high;
      logic [WORD_WIDTH-1:0] result_low;
   } rsp_payload_type;

   // Working state of one block as it moves down the pipeline.
   typedef struct packed {
      logic                  decrypt;
      logic [WORD_WIDTH-1:0] y;
      logic [WORD_WIDTH-1:0] z;
   } block_type;

   function automatic logic [WORD_WIDTH-1:0] xt_mix(input logic [WORD_WIDTH-1:0] w);
      return ((w << 4) ^ (w >> 5)) + w;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/xtea_stage.sv @@
`default_nettype none

// One Feistel half-round with its own output register. The round sum and the
// key word selection are fixed per stage, for both directions.
module xtea_stage import xtea_pkg::*; #(
   parameter int unsigned CYCLE_COUNT = 32,
   parameter int unsigned HALF_ROUND  = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  block_type in_block,
   input  key_type   key,
   output logic      out_valid,
   input  logic      out_ready,
   output block_type out_block
);

   localparam int unsigned CYCLE_IDX = HALF_ROUND / 2;
   localparam logic        ODD       = 1'(HALF_ROUND % 2);

   localparam int unsigned ENC_MULT = (HALF_ROUND % 2 == 1) ? CYCLE_IDX + 1 : CYCLE_IDX;
   localparam int unsigned DEC_MULT = (HALF_ROUND % 2 == 1) ?
                                      CYCLE_COUNT - CYCLE_IDX - 1 : CYCLE_COUNT - CYCLE_IDX;

   localparam logic [WORD_WIDTH-1:0] ENC_SUM = WORD_WIDTH'(64'(ENC_MULT) * 64'(XT_DELTA));
   localparam logic [WORD_WIDTH-1:0] DEC_SUM = WORD_WIDTH'(64'(DEC_MULT) * 64'(XT_DELTA));

   // Encryption uses the low sum bits on the first half-round of a cycle and the
   // shifted bits on the second; decryption runs the other way around.
   localparam logic [1:0] ENC_KEY_SEL = (HALF_ROUND % 2 == 1) ?
                                        ENC_SUM[XT_SEL_SHIFT +: 2] : ENC_SUM[1:0];
   localparam logic [1:0] DEC_KEY_SEL = (HALF_ROUND % 2 == 1) ?
                                        DEC_SUM[1:0] : DEC_SUM[XT_SEL_SHIFT +: 2];

   logic                  valid_ff;
   logic                  valid_in;
   block_type             block_ff;
   block_type             block_in;
   logic                  update_y;
   logic [WORD_WIDTH-1:0] mix_src;
   logic [WORD_WIDTH-1:0] dst;
   logic [WORD_WIDTH-1:0] round_key;
   logic [WORD_WIDTH-1:0] term;
   logic [WORD_WIDTH-1:0] result;
   block_type             next_block;

   always_comb begin
      update_y  = (in_block.decrypt == ODD);
      mix_src   = update_y ? in_block.z : in_block.y;
      dst       = update_y ? in_block.y : in_block.z;
      round_key = in_block.decrypt ? (DEC_SUM + key[DEC_KEY_SEL])
                                   : (ENC_SUM + key[ENC_KEY_SEL]);
      term      = xt_mix(mix_src) ^ round_key;
      result    = in_block.decrypt ? (dst - term) : (dst + term);

      next_block         = in_block;
      next_block.y       = update_y ? result : in_block.y;
      next_block.z       = update_y ? in_block.z : result;
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      block_in = (in_ready && in_valid) ? next_block : block_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
   end

   assign out_valid = valid_ff;
   assign out_block = block_ff;

endmodule

`default_nettype wire

@@ rtl/core/xtea_block_cipher.sv @@
// XTEA block cipher, 64-bit block, 128-bit key, fully pipelined.
//
// Request channel (req_): one beat carries a 64-bit block as block_high and
// block_low, plus a decrypt flag that selects decryption instead of encryption.
// Response channel (rsp_): one beat per request, in request order, carrying the
// transformed halves. Both channels use valid/ready handshakes.
// Configuration port (csr_): a write with csr_write high loads the 32-bit key
// word chosen by csr_index. Keys must be changed only while the pipeline is
// empty; blocks already in flight read the key registers as they pass.
// Structure and throughput: the pipeline holds 2*CYCLE_COUNT stages, one Feistel
// half-round each (one add/xor chain per register). A new block can enter on
// every clock while rsp_ready is high.
// Reset: synchronous; it empties the pipeline and clears the key to zero.
// Back-pressure: when rsp_ready is low the final stage holds its beat and each
// stage still accepts data while it is empty, so bubbles close up and the
// request side stalls only when every stage is full.
`default_nettype none

module xtea_block_cipher import xtea_pkg::*; #(
   parameter int unsigned CYCLE_COUNT = 32
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,

   input  logic                  csr_write,
   input  csr_index_type         csr_index,
   input  logic [WORD_WIDTH-1:0] csr_data
);

   localparam int unsigned STAGES = 2 * CYCLE_COUNT;

   key_type key_ff;
   key_type key_in;

   // Key registers. Every index code names a register, so no write is dropped.
   always_comb begin
      key_in = key_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_WORD0: key_in[0] = csr_data;
            CSR_KEY_WORD1: key_in[1] = csr_data;
            CSR_KEY_WORD2: key_in[2] = csr_data;
            CSR_KEY_WORD3: key_in[3] = csr_data;
            default:       key_in    = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // Link s feeds stage s; link STAGES is the pipeline output.
   logic [STAGES:0] link_valid;
   logic [STAGES:0] link_ready;
   block_type       link_block [STAGES+1];

   assign link_valid[0]         = req_valid;
   assign link_block[0].decrypt = req_payload.decrypt;
   assign link_block[0].y       = req_payload.block_high;
   assign link_block[0].z       = req_payload.block_low;
   assign req_ready             = link_ready[0];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      xtea_stage #(
         .CYCLE_COUNT (CYCLE_COUNT),
         .HALF_ROUND  (s)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[s]),
         .in_ready  (link_ready[s]),
         .in_block  (link_block[s]),
         .key       (key_ff),
         .out_valid (link_valid[s+1]),
         .out_ready (link_ready[s+1]),
         .out_block (link_block[s+1])
      );
   end

   // The last stage register is the output register.
   assign link_ready[STAGES]      = rsp_ready;
   assign rsp_valid               = link_valid[STAGES];
   assign rsp_payload.result_high = link_block[STAGES].y;
   assign rsp_payload.result_low  = link_block[STAGES].z;

   // The number of blocks in flight changes only by accepted requests and
   // delivered responses, so no block is lost or duplicated inside the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      $countones(link_valid[STAGES:1]) ==
         $past($countones(link_valid[STAGES:1])) + $past(req_valid && req_ready)
         - $past(rsp_valid && rsp_ready))
      else $error("pipeline occupancy does not match accepted and delivered beats");

   // The second-to-last stage, when full and blocked, keeps its block until the last stage frees up.
   assert property (@(posedge clock) disable iff (reset)
      link_valid[STAGES-1] && !link_ready[STAGES-1]
         |=> link_valid[STAGES-1] && $stable(link_block[STAGES-1]))
      else $error("stalled stage changed its block");

   // A response still waiting for rsp_ready must not block an empty first stage.
   assert property (@(posedge clock) disable iff (reset)
      !link_valid[1] |-> req_ready)
      else $error("request refused while first stage is empty");

endmodule

`default_nettype wire
